// ----- hdl/caloc_pkg.sv -----
// shared types and constants for the contiguous allocator
// no dependencies
package caloc_pkg;

  localparam int unsigned SZ_W          = 13;
  localparam int unsigned NAME_W        = 32;
  localparam int unsigned MAX_FILES_DEF = 16;
  localparam int unsigned MAX_HOLES_DEF = 16;
  localparam logic [SZ_W-1:0] REGION_RESET = 13'd500;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_DEL   = 2'd1;

  localparam logic [2:0] ST_ALLOC     = 3'd0;
  localparam logic [2:0] ST_ALLOC_CMP = 3'd1;
  localparam logic [2:0] ST_NOSPACE   = 3'd2;
  localparam logic [2:0] ST_DELETED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_COMPACT   = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_IDX0  = 4'd2;
  localparam logic [3:0] OP_HRD   = 4'd3;
  localparam logic [3:0] OP_HCHK  = 4'd4;
  localparam logic [3:0] OP_PLACE = 4'd5;
  localparam logic [3:0] OP_FRD   = 4'd6;
  localparam logic [3:0] OP_CWR   = 4'd7;
  localparam logic [3:0] OP_CFIN  = 4'd8;
  localparam logic [3:0] OP_INC   = 4'd9;
  localparam logic [3:0] OP_DREC  = 4'd10;
  localparam logic [3:0] OP_SRD   = 4'd11;
  localparam logic [3:0] OP_SWR   = 4'd12;
  localparam logic [3:0] OP_DDEC  = 4'd13;
  localparam logic [3:0] OP_RES   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       idx_end_h;
    logic       idx_end_f;
    logic       last_f;
    logic       files_full;
    logic       holes_full;
    logic       hit;
    logic       match;
    logic       out_free;
    logic [1:0] func;
  } stat_t;

endpackage

// ----- hdl/caloc_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module caloc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hdl/caloc_dp.sv -----
// datapath: file and hole tables, counters, walk index and result register
// depends on caloc_pkg and caloc_ram
module caloc_dp #(
  parameter int unsigned MAX_FILES = caloc_pkg::MAX_FILES_DEF,
  parameter int unsigned MAX_HOLES = caloc_pkg::MAX_HOLES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  caloc_pkg::cmd_t     cmd_i,
  output caloc_pkg::stat_t    stat_o,
  input  logic                cfg_we_i,
  input  logic [12:0]         cfg_data_i,
  input  logic [47:0]         in_data_i,
  input  logic [1:0]          in_user_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [15:0]         m_data_o,
  output logic [2:0]          m_user_o
);

  localparam int unsigned SW  = caloc_pkg::SZ_W;
  localparam int unsigned NW  = caloc_pkg::NAME_W;
  localparam int unsigned FAW = $clog2(MAX_FILES);
  localparam int unsigned HAW = $clog2(MAX_HOLES);
  localparam int unsigned FCW = $clog2(MAX_FILES + 1);
  localparam int unsigned HCW = $clog2(MAX_HOLES + 1);
  localparam int unsigned IW  = (FCW > HCW) ? FCW : HCW;
  localparam int unsigned PW  = SW + FCW;
  localparam int unsigned FEW = NW + 2 * SW;
  localparam int unsigned HEW = 2 * SW;

  logic [SW-1:0]  region_q;
  logic [FCW-1:0] fcount_q;
  logic [HCW-1:0] hcount_q;
  logic           dflt_q, rd_dflt_q;
  logic [IW-1:0]  idx_q;
  logic [PW-1:0]  pos_q;
  logic           hit_q;
  logic [HAW-1:0] hit_idx_q;
  logic [SW-1:0]  hit_start_q, hit_size_q;
  logic [NW-1:0]  name_q;
  logic [SW-1:0]  size_q, off_q;
  logic [1:0]     func_q;
  logic           mvalid_q;
  logic [2:0]     mstatus_q;
  logic [SW-1:0]  moff_q;

  logic           f_we, h_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [HAW-1:0] h_waddr;
  logic [FEW-1:0] f_wdata, f_rdata;
  logic [HEW-1:0] h_wdata, h_rdata;
  logic [NW-1:0]  f_name;
  logic [SW-1:0]  f_size, f_start, h_start, h_size, cmp_size;
  logic [IW-1:0]  idx_p1;
  logic [PW-1:0]  region_ext, rem;
  logic           out_free;

  assign f_name  = f_rdata[FEW-1 -: NW];
  assign f_size  = f_rdata[2*SW-1 -: SW];
  assign f_start = f_rdata[SW-1:0];
  assign h_start = rd_dflt_q ? '0 : h_rdata[HEW-1 -: SW];
  assign h_size  = rd_dflt_q ? region_q : h_rdata[SW-1:0];
  assign idx_p1  = idx_q + IW'(1);
  assign region_ext = PW'(region_q);
  assign rem      = region_ext - pos_q;
  assign cmp_size = (region_ext > pos_q) ? rem[SW-1:0] : '0;
  assign out_free = !mvalid_q || m_ready_i;

  always_comb begin
    f_raddr = (cmd_i.op == caloc_pkg::OP_SRD) ? idx_p1[FAW-1:0] : idx_q[FAW-1:0];
    f_we    = 1'b0;
    f_waddr = idx_q[FAW-1:0];
    f_wdata = f_rdata;
    h_we    = 1'b0;
    h_waddr = '0;
    h_wdata = {pos_q[SW-1:0], cmp_size};
    case (cmd_i.op)
      caloc_pkg::OP_PLACE: begin
        f_we    = 1'b1;
        f_waddr = fcount_q[FAW-1:0];
        f_wdata = {name_q, size_q, hit_start_q};
        h_we    = 1'b1;
        h_waddr = hit_idx_q;
        h_wdata = {hit_start_q + size_q, hit_size_q - size_q};
      end
      caloc_pkg::OP_CWR: begin
        f_we    = 1'b1;
        f_wdata = {f_name, f_size, pos_q[SW-1:0]};
      end
      caloc_pkg::OP_SWR: begin
        f_we = 1'b1;
      end
      caloc_pkg::OP_DREC: begin
        h_we    = !stat_o.holes_full;
        h_waddr = hcount_q[HAW-1:0];
        h_wdata = {f_start, f_size};
      end
      caloc_pkg::OP_CFIN: begin
        h_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  caloc_ram #(.WIDTH(FEW), .DEPTH(MAX_FILES)) u_files (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  caloc_ram #(.WIDTH(HEW), .DEPTH(MAX_HOLES)) u_holes (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (idx_q[HAW-1:0]),
    .rdata_o (h_rdata)
  );

  always_comb begin
    stat_o.idx_end_h  = idx_q >= IW'(hcount_q);
    stat_o.idx_end_f  = idx_q >= IW'(fcount_q);
    stat_o.last_f     = idx_p1 >= IW'(fcount_q);
    stat_o.files_full = fcount_q == FCW'(MAX_FILES);
    stat_o.holes_full = hcount_q == HCW'(MAX_HOLES);
    stat_o.hit        = hit_q;
    stat_o.match      = f_name == name_q;
    stat_o.out_free   = out_free;
    stat_o.func       = func_q;
  end

  // counters, table defaults and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q  <= caloc_pkg::REGION_RESET;
      fcount_q  <= '0;
      hcount_q  <= HCW'(1);
      dflt_q    <= 1'b1;
      rd_dflt_q <= 1'b0;
      idx_q     <= '0;
      pos_q     <= '0;
      hit_q     <= 1'b0;
      mvalid_q  <= 1'b0;
    end else begin
      rd_dflt_q <= (cmd_i.op == caloc_pkg::OP_HRD) && dflt_q && (idx_q == '0);
      if (mvalid_q && m_ready_i) begin
        mvalid_q <= 1'b0;
      end
      case (cmd_i.op)
        caloc_pkg::OP_LATCH, caloc_pkg::OP_IDX0: begin
          idx_q <= '0;
          pos_q <= '0;
          hit_q <= 1'b0;
        end
        caloc_pkg::OP_HCHK: begin
          if (h_size >= size_q) begin
            hit_q <= 1'b1;
          end
          idx_q <= idx_p1;
        end
        caloc_pkg::OP_PLACE: begin
          fcount_q <= fcount_q + FCW'(1);
          if (hit_idx_q == '0) begin
            dflt_q <= 1'b0;
          end
        end
        caloc_pkg::OP_CWR: begin
          pos_q <= pos_q + PW'(f_size);
          idx_q <= idx_p1;
        end
        caloc_pkg::OP_CFIN: begin
          hcount_q <= HCW'(1);
          dflt_q   <= 1'b0;
          idx_q    <= '0;
          hit_q    <= 1'b0;
        end
        caloc_pkg::OP_INC, caloc_pkg::OP_SWR: begin
          idx_q <= idx_p1;
        end
        caloc_pkg::OP_DREC: begin
          if (!stat_o.holes_full) begin
            hcount_q <= hcount_q + HCW'(1);
          end
        end
        caloc_pkg::OP_DDEC: begin
          fcount_q <= fcount_q - FCW'(1);
          idx_q    <= '0;
          pos_q    <= '0;
        end
        caloc_pkg::OP_RES: begin
          mvalid_q <= 1'b1;
        end
        default: begin
        end
      endcase
      if (cfg_we_i) begin
        region_q <= cfg_data_i;
        fcount_q <= '0;
        hcount_q <= HCW'(1);
        dflt_q   <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      caloc_pkg::OP_LATCH: begin
        name_q <= in_data_i[NW-1:0];
        size_q <= in_data_i[NW+SW-1:NW];
        func_q <= in_user_i;
      end
      caloc_pkg::OP_HCHK: begin
        if (h_size >= size_q) begin
          hit_idx_q   <= idx_q[HAW-1:0];
          hit_start_q <= h_start;
          hit_size_q  <= h_size;
        end
      end
      caloc_pkg::OP_PLACE: begin
        off_q <= hit_start_q;
      end
      caloc_pkg::OP_RES: begin
        mstatus_q <= cmd_i.code;
        moff_q    <= (cmd_i.code == caloc_pkg::ST_ALLOC ||
                      cmd_i.code == caloc_pkg::ST_ALLOC_CMP) ? off_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign m_valid_o = mvalid_q;
  assign m_data_o  = {3'b000, moff_q};
  assign m_user_o  = mstatus_q;

  a_hcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcount_q != '0 && hcount_q <= HCW'(MAX_HOLES))
    else $error("hole count out of range");
  a_fcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= FCW'(MAX_FILES))
    else $error("file count out of range");
  a_place_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == caloc_pkg::OP_PLACE |-> hit_q && !stat_o.files_full)
    else $error("placement without a fitting hole");
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == caloc_pkg::OP_RES |-> out_free)
    else $error("result overwrites a pending beat");

endmodule

// ----- hdl/caloc_ctrl.sv -----
// controller state machine sequencing scans, compaction and deletes
// depends on caloc_pkg
module caloc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             idle_o,
  input  caloc_pkg::stat_t stat_i,
  output caloc_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_HRD  = 4'd2;
  localparam logic [3:0] S_HCHK = 4'd3;
  localparam logic [3:0] S_HDEC = 4'd4;
  localparam logic [3:0] S_CRD  = 4'd5;
  localparam logic [3:0] S_CWR  = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_SRD  = 4'd9;
  localparam logic [3:0] S_SWR  = 4'd10;
  localparam logic [3:0] S_RES  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       retry_q, retry_d, full_q, full_d, ret_q, ret_d;
  logic [2:0] code_q, code_d;

  always_comb begin
    state_d = state_q;
    retry_d = retry_q;
    full_d  = full_q;
    ret_d   = ret_q;
    code_d  = code_q;
    cmd_o.op   = caloc_pkg::OP_NONE;
    cmd_o.code = code_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = caloc_pkg::OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        retry_d = 1'b0;
        case (stat_i.func)
          caloc_pkg::FN_ALLOC: begin
            if (stat_i.files_full) begin
              code_d  = caloc_pkg::ST_FULL;
              state_d = S_RES;
            end else begin
              cmd_o.op = caloc_pkg::OP_IDX0;
              state_d  = S_HRD;
            end
          end
          caloc_pkg::FN_DEL: begin
            cmd_o.op = caloc_pkg::OP_IDX0;
            state_d  = S_FRD;
          end
          default: begin
            cmd_o.op = caloc_pkg::OP_IDX0;
            ret_d    = 1'b0;
            code_d   = caloc_pkg::ST_COMPACT;
            state_d  = S_CRD;
          end
        endcase
      end
      S_HRD: begin
        if (stat_i.idx_end_h) begin
          state_d = S_HDEC;
        end else begin
          cmd_o.op = caloc_pkg::OP_HRD;
          state_d  = S_HCHK;
        end
      end
      S_HCHK: begin
        cmd_o.op = caloc_pkg::OP_HCHK;
        state_d  = S_HRD;
      end
      S_HDEC: begin
        if (stat_i.hit) begin
          cmd_o.op = caloc_pkg::OP_PLACE;
          code_d   = retry_q ? caloc_pkg::ST_ALLOC_CMP : caloc_pkg::ST_ALLOC;
          state_d  = S_RES;
        end else if (retry_q) begin
          code_d  = caloc_pkg::ST_NOSPACE;
          state_d = S_RES;
        end else begin
          retry_d  = 1'b1;
          ret_d    = 1'b1;
          cmd_o.op = caloc_pkg::OP_IDX0;
          state_d  = S_CRD;
        end
      end
      S_CRD: begin
        if (stat_i.idx_end_f) begin
          cmd_o.op = caloc_pkg::OP_CFIN;
          state_d  = ret_q ? S_HRD : S_RES;
        end else begin
          cmd_o.op = caloc_pkg::OP_FRD;
          state_d  = S_CWR;
        end
      end
      S_CWR: begin
        cmd_o.op = caloc_pkg::OP_CWR;
        state_d  = S_CRD;
      end
      S_FRD: begin
        if (stat_i.idx_end_f) begin
          code_d  = caloc_pkg::ST_NOTFOUND;
          state_d = S_RES;
        end else begin
          cmd_o.op = caloc_pkg::OP_FRD;
          state_d  = S_FCHK;
        end
      end
      S_FCHK: begin
        if (stat_i.match) begin
          cmd_o.op = caloc_pkg::OP_DREC;
          full_d   = stat_i.holes_full;
          state_d  = S_SRD;
        end else begin
          cmd_o.op = caloc_pkg::OP_INC;
          state_d  = S_FRD;
        end
      end
      S_SRD: begin
        if (stat_i.last_f) begin
          cmd_o.op = caloc_pkg::OP_DDEC;
          code_d   = caloc_pkg::ST_DELETED;
          ret_d    = 1'b0;
          state_d  = full_q ? S_CRD : S_RES;
        end else begin
          cmd_o.op = caloc_pkg::OP_SRD;
          state_d  = S_SWR;
        end
      end
      S_SWR: begin
        cmd_o.op = caloc_pkg::OP_SWR;
        state_d  = S_SRD;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.op = caloc_pkg::OP_RES;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      retry_q <= 1'b0;
      full_q  <= 1'b0;
      ret_q   <= 1'b0;
      code_q  <= caloc_pkg::ST_ALLOC;
    end else begin
      state_q <= state_d;
      retry_q <= retry_d;
      full_q  <= full_d;
      ret_q   <= ret_d;
      code_q  <= code_d;
    end
  end

  assign idle_o = state_q == S_IDLE;

endmodule

// ----- hdl/contiguous_allocator_with_compaction_top.sv -----
// Contiguous region allocator with a file table and a free-hole table, one
// request at a time. An allocate scans the holes, unless the file table is
// full, and a failed scan compacts the file table and rescans. A delete
// searches and then shifts the file table, and compacts when the hole table
// is full. A compact request compacts the file table. A result waits on the
// output until the previous result has been taken. A new request is taken
// while the previous result still waits on the output.
// depends on caloc_pkg, caloc_ctrl, caloc_dp, caloc_ram
module contiguous_allocator_with_compaction_top #(
  parameter int unsigned MAX_FILES = caloc_pkg::MAX_FILES_DEF,
  parameter int unsigned MAX_HOLES = caloc_pkg::MAX_HOLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,      // region_size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // file_name[31:0], request_size[44:32]
  input  logic [1:0]  s_axis_tuser_i,  // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // start_offset[12:0]
  output logic [2:0]  m_axis_tuser_o   // status[2:0]
);

  caloc_pkg::cmd_t  cmd;
  caloc_pkg::stat_t stat;
  logic             idle;

  assign s_axis_tready_o = idle;
  assign cfg_ready_o     = idle;

  caloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .idle_o     (idle),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  caloc_dp #(.MAX_FILES(MAX_FILES), .MAX_HOLES(MAX_HOLES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_valid_i && idle),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_data_o   (m_axis_tdata_o),
    .m_user_o   (m_axis_tuser_o)
  );

endmodule
